/* rtl/core/bcmp_pkg.sv */
// ----------------------------------------------------------------------------
// barometer compensation package
// shared widths, trim register indexes and helper functions
// ----------------------------------------------------------------------------
package bcmp_pkg;

    localparam int CfgDataW = 64;
    localparam int CfgIdxW  = 2;
    localparam int DivW     = 32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TRIM_SIGNED_AC   = 2'd0,
        REG_TRIM_UNSIGNED_AC = 2'd1,
        REG_TRIM_B_AND_M     = 2'd2,
        REG_UNUSED           = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [47:0] signed_ac;
        logic [47:0] unsigned_ac;
        logic [63:0] b_and_m;
    } t_trim;

    // side data carried through a divider
    typedef struct packed {
        logic [15:0] up;
        logic [31:0] b5;
        logic        fault;
    } t_tag;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        asr = 32'($signed(v) >>> n);
    endfunction

endpackage

/* rtl/core/bcmp_if.sv */
// ----------------------------------------------------------------------------
// barometer compensation channels
// valid/ready channels for raw readings and compensated results
// ----------------------------------------------------------------------------
interface bcmp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;
    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bcmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [27:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_fault;
    modport source (output valid, temperature_tenths, pressure_pa, divide_fault,
                    input ready);
    modport sink   (input valid, temperature_tenths, pressure_pa, divide_fault,
                    output ready);
endinterface

/* rtl/core/bcmp_div.sv */
// ----------------------------------------------------------------------------
// pipelined divider
// restoring divide, one quotient bit per stage, signed or unsigned
// ----------------------------------------------------------------------------
module bcmp_div
    import bcmp_pkg::*;
#(
    parameter bit IsSigned = 1'b1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [DivW-1:0] i_num,
    input  logic [DivW-1:0] i_den,
    input  t_tag            i_tag,
    output logic            o_valid,
    output logic [DivW-1:0] o_quo,
    output t_tag            o_tag
);
    logic            r_v   [DivW+1];
    logic [DivW-1:0] r_rem [DivW+1];
    logic [DivW-1:0] r_q   [DivW+1];
    logic [DivW-1:0] r_d   [DivW+1];
    logic            r_neg [DivW+1];
    t_tag            r_tag [DivW+1];

    logic            n_na, n_da;

    assign n_na = IsSigned & i_num[DivW-1];
    assign n_da = IsSigned & i_den[DivW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DivW; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= DivW; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_q[0]   <= n_na ? -i_num : i_num;
            r_d[0]   <= n_da ? -i_den : i_den;
            r_neg[0] <= n_na ^ n_da;
            r_tag[0] <= i_tag;
            for (int k = 1; k <= DivW; k++) begin
                logic [DivW:0] t;
                t = {r_rem[k-1], r_q[k-1][DivW-1]};
                if (t >= {1'b0, r_d[k-1]}) begin
                    r_rem[k] <= DivW'(t - {1'b0, r_d[k-1]});
                    r_q[k]   <= {r_q[k-1][DivW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= DivW'(t);
                    r_q[k]   <= {r_q[k-1][DivW-2:0], 1'b0};
                end
                r_d[k]   <= r_d[k-1];
                r_neg[k] <= r_neg[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_v[DivW];
    assign o_quo   = r_neg[DivW] ? -r_q[DivW] : r_q[DivW];
    assign o_tag   = r_tag[DivW];
endmodule

/* rtl/core/barometer_compensation_core.sv */
// ----------------------------------------------------------------------------
// barometer compensation core
// raw temperature and pressure to tenths of a degree and pascals
// ----------------------------------------------------------------------------
// path: stages a and b, temperature divider, stages c to h, pressure divider, stages i and j, output register
// throughput: one beat per cycle while the output is not stalled, set by the fully pipelined dividers
// the whole pipe advances while the output register is empty or taken
// reset: synchronous active low, clears valid bits and trim registers
module barometer_compensation_core
    import bcmp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    bcmp_in_if.sink             in_ch,
    bcmp_out_if.source          out_ch
);
    t_trim r_trim;
    logic  n_en;

    // global stall: the pipe moves when the output slot frees
    assign n_en     = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TRIM_SIGNED_AC:   r_trim.signed_ac   <= i_cfg_data[47:0];
                REG_TRIM_UNSIGNED_AC: r_trim.unsigned_ac <= i_cfg_data[47:0];
                REG_TRIM_B_AND_M:     r_trim.b_and_m     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(r_trim.signed_ac[47:32]);
    assign ac2 = sx16(r_trim.signed_ac[31:16]);
    assign ac3 = sx16(r_trim.signed_ac[15:0]);
    assign ac4 = {16'd0, r_trim.unsigned_ac[47:32]};
    assign ac5 = {16'd0, r_trim.unsigned_ac[31:16]};
    assign ac6 = {16'd0, r_trim.unsigned_ac[15:0]};
    assign b1  = sx16(r_trim.b_and_m[63:48]);
    assign b2  = sx16(r_trim.b_and_m[47:32]);
    assign mc  = sx16(r_trim.b_and_m[31:16]);
    assign md  = sx16(r_trim.b_and_m[15:0]);

    // stage a: x1 product
    logic        r_av;
    logic [31:0] r_ax1p;
    logic [15:0] r_aup;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (n_en) r_av <= in_ch.valid;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_ax1p <= ({16'd0, in_ch.raw_temperature} - ac6) * ac5;
            r_aup  <= in_ch.raw_pressure;
        end
    end

    // stage b: x1 and temperature divisor
    logic        r_bv;
    logic [31:0] r_bx1, r_bden;
    logic [15:0] r_bup;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (n_en) r_bv <= r_av;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_bx1  <= asr(r_ax1p, 15);
            r_bden <= asr(r_ax1p, 15) + md;
            r_bup  <= r_aup;
        end
    end

    // temperature divider, x1 rides in the b5 slot of the tag
    logic        d1_v;
    logic [31:0] d1_q;
    t_tag        d1_tag, d1_in;
    assign d1_in = '{up: r_bup, b5: r_bx1, fault: (r_bden == 32'd0)};
    bcmp_div #(.IsSigned(1'b1)) u_div_t (
        .i_clk, .i_rst_n, .i_en(n_en), .i_valid(r_bv),
        .i_num(mc << 11), .i_den(r_bden), .i_tag(d1_in),
        .o_valid(d1_v), .o_quo(d1_q), .o_tag(d1_tag)
    );

    // stage c: b5, b6
    logic        r_cv, r_cf;
    logic [31:0] r_cb5, r_cb6;
    logic [15:0] r_cup;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else if (n_en) r_cv <= d1_v;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_cb5 <= d1_tag.b5 + d1_q;
            r_cb6 <= d1_tag.b5 + d1_q - 32'd4000;
            r_cf  <= d1_tag.fault;
            r_cup <= d1_tag.up;
        end
    end

    // stage d: b6 squared and linear products
    logic        r_dv, r_df;
    logic [31:0] r_db5, r_dsq, r_dac2, r_dac3;
    logic [15:0] r_dup;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= 1'b0;
        else if (n_en) r_dv <= r_cv;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_dsq  <= asr(r_cb6 * r_cb6, 12);
            r_dac2 <= asr(ac2 * r_cb6, 11);
            r_dac3 <= asr(ac3 * r_cb6, 13);
            r_db5  <= r_cb5;
            r_df   <= r_cf;
            r_dup  <= r_cup;
        end
    end

    // stage e: trim products on b6 squared
    logic        r_ev, r_ef;
    logic [31:0] r_eb5, r_eb2, r_eb1, r_eac2, r_eac3;
    logic [15:0] r_eup;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ev <= 1'b0;
        else if (n_en) r_ev <= r_dv;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_eb2  <= asr(b2 * r_dsq, 11);
            r_eb1  <= asr(b1 * r_dsq, 16);
            r_eac2 <= r_dac2;
            r_eac3 <= r_dac3;
            r_eb5  <= r_db5;
            r_ef   <= r_df;
            r_eup  <= r_dup;
        end
    end

    // stage f: b3 and x3; divide by four truncates toward zero
    logic        r_fv, r_ff;
    logic [31:0] r_fb5, r_fb3, r_fx3;
    logic [15:0] r_fup;
    logic [31:0] n_b3n;
    assign n_b3n = (ac1 << 2) + r_eb2 + r_eac2 + 32'd2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fv <= 1'b0;
        else if (n_en) r_fv <= r_ev;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_fb3 <= asr(n_b3n + (n_b3n[31] ? 32'd3 : 32'd0), 2);
            r_fx3 <= asr(r_eac3 + r_eb1 + 32'd2, 2);
            r_fb5 <= r_eb5;
            r_ff  <= r_ef;
            r_fup <= r_eup;
        end
    end

    // stage g: b4 product and b7 product
    logic        r_gv, r_gf;
    logic [31:0] r_gb5, r_gb4p, r_gb7;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gv <= 1'b0;
        else if (n_en) r_gv <= r_fv;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_gb4p <= ac4 * (r_fx3 + 32'd32768);
            r_gb7  <= ({16'd0, r_fup} - r_fb3) * 32'd50000;
            r_gb5  <= r_fb5;
            r_gf   <= r_ff;
        end
    end

    // stage h: b4 and the numerator; b7 high keeps its post-divide doubling
    logic        r_hv, r_hf, r_hhi;
    logic [31:0] r_hb5, r_hb4, r_hnum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hv <= 1'b0;
        else if (n_en) r_hv <= r_gv;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_hb4  <= r_gb4p >> 15;
            r_hhi  <= r_gb7[31];
            r_hnum <= r_gb7[31] ? r_gb7 : (r_gb7 << 1);
            r_hb5  <= r_gb5;
            r_hf   <= r_gf;
        end
    end

    logic        d2_v;
    logic [31:0] d2_q;
    t_tag        d2_tag, d2_in;
    assign d2_in = '{up: {15'd0, r_hhi}, b5: r_hb5, fault: r_hf || (r_hb4 == 32'd0)};
    bcmp_div #(.IsSigned(1'b0)) u_div_p (
        .i_clk, .i_rst_n, .i_en(n_en), .i_valid(r_hv),
        .i_num(r_hnum), .i_den(r_hb4), .i_tag(d2_in),
        .o_valid(d2_v), .o_quo(d2_q), .o_tag(d2_tag)
    );

    // stage i: p and its shifted square, the 7357 product
    logic        r_iv, r_if;
    logic [31:0] r_ip, r_isq, r_im, r_ib5;
    logic [31:0] n_p;
    assign n_p = d2_tag.up[0] ? (d2_q << 1) : d2_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_iv <= 1'b0;
        else if (n_en) r_iv <= d2_v;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_ip  <= n_p;
            r_isq <= asr(n_p, 8) * asr(n_p, 8);
            r_im  <= 32'd0 - (32'd7357 * n_p);
            r_ib5 <= d2_tag.b5;
            r_if  <= d2_tag.fault;
        end
    end

    // stage j: 3038 product and the shifted 7357 product
    logic        r_jv, r_jf;
    logic [31:0] r_jp, r_jx1, r_jx2, r_jb5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_jv <= 1'b0;
        else if (n_en) r_jv <= r_iv;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_jx1 <= asr(r_isq * 32'd3038, 16);
            r_jx2 <= asr(r_im, 16);
            r_jp  <= r_ip;
            r_jb5 <= r_ib5;
            r_jf  <= r_if;
        end
    end

    // output register, zeroed on a divide fault
    logic        r_ov, r_of;
    logic [27:0] r_ot;
    logic [31:0] r_op, n_t;
    assign n_t = asr(r_jb5 + 32'd8, 4);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (n_en) r_ov <= r_jv;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_of <= r_jf;
            r_ot <= r_jf ? 28'd0 : n_t[27:0];
            r_op <= r_jf ? 32'd0 : r_jp + asr(r_jx1 + r_jx2 + 32'd3791, 4);
        end
    end

    assign out_ch.valid              = r_ov;
    assign out_ch.divide_fault       = r_of;
    assign out_ch.temperature_tenths = r_ot;
    assign out_ch.pressure_pa        = r_op;
endmodule

/* rtl/core/bcmp_checker.sv */
// ----------------------------------------------------------------------------
// barometer compensation checker
// port level checks on the input ready and the result channel
// ----------------------------------------------------------------------------
module bcmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_fault,
    input logic [27:0] i_temp,
    input logic [31:0] i_pres
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pres))
        else $error("result beat dropped while stalled");
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fault |-> i_temp == 28'd0 && i_pres == 32'd0)
        else $error("fault beat carries nonzero data");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready disagrees with output slot");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");
endmodule

bind barometer_compensation_core bcmp_checker u_bcmp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
    .i_fault(out_ch.divide_fault), .i_temp(out_ch.temperature_tenths),
    .i_pres(out_ch.pressure_pa)
);
